### rtl/tqts_pkg.sv
// Shared types and codes for the task queue and timer scheduler.
`default_nettype none

package tqts_pkg;

  localparam int unsigned IdFieldW = 8;
  localparam int unsigned DelayW   = 8;
  localparam int unsigned CountW   = 4;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_TIMED    = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_DISPATCH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_QFULL = 2'd1,
    ST_TFULL = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [IdFieldW-1:0] task_id;
    logic [DelayW-1:0]   delay;
  } req_t;

  typedef struct packed {
    logic [IdFieldW-1:0] head_task;
    logic                dispatched;
    status_e             status;
    logic [CountW-1:0]   ready_count;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic need_walk;
    logic walk_done;
  } stat_t;

endpackage

`default_nettype wire

### rtl/tqts_ctrl.sv
// Sequencer for the scheduler: latch, walk the timer table, finish.
`default_nettype none

module tqts_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  tqts_pkg::stat_t     stat_i,
  output tqts_pkg::ctl_t      ctl_o
);
  import tqts_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_READ  = 5'b00100,
    S_PROC  = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          state_d    = S_SETUP;
        end
      end
      S_SETUP: begin
        state_d = stat_i.need_walk ? S_READ : S_FIN;
      end
      S_READ: begin
        state_d = S_PROC;
      end
      S_PROC: begin
        ctl_o.step = 1'b1;
        state_d    = stat_i.walk_done ? S_FIN : S_READ;
      end
      S_FIN: begin
        ctl_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

### rtl/tqts_dp.sv
// Datapath: ready queue ring buffer, timer table memory and result register.
`default_nettype none

module tqts_dp #(
  parameter int unsigned QUEUE_SLOTS  = 8,
  parameter int unsigned TIMER_SLOTS  = 8,
  parameter int unsigned TASK_ID_BITS = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  tqts_pkg::req_t      req_i,
  input  tqts_pkg::ctl_t      ctl_i,
  output tqts_pkg::stat_t     stat_o,
  output tqts_pkg::res_t      res_o,
  output logic                done_o
);
  import tqts_pkg::*;

  localparam int unsigned IdW = (TASK_ID_BITS < IdFieldW) ? TASK_ID_BITS : IdFieldW;
  localparam int unsigned QIW = $clog2(QUEUE_SLOTS);
  localparam int unsigned FW  = $clog2(QUEUE_SLOTS + 1);
  localparam int unsigned TIW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  typedef struct packed {
    logic [IdW-1:0]    task_id;
    logic [DelayW-1:0] count;
  } slot_t;

  // latched item
  cmd_e              cmd_q;
  logic [IdW-1:0]    id_q;
  logic [DelayW-1:0] delay_q;

  // ready queue
  logic [IdW-1:0] qmem [QUEUE_SLOTS];
  logic [IdW-1:0] qrd_q;
  logic [QIW-1:0] head_q, head_d, tail_q, tail_d;
  logic [FW-1:0]  fill_q, fill_d;

  // timer table
  slot_t            tmem [TIMER_SLOTS];
  slot_t            trd_q;
  logic [TIMER_SLOTS-1:0] tvalid_q, tvalid_d;
  logic [TIW-1:0]   idx_q, free_idx_q;
  logic             hit_q, free_found_q;

  status_e status_q, status_d;
  res_t    res_q;
  logic    done_q;

  logic           need_walk, cur_valid, last_slot, match;
  logic           push_req, push_do, push_lost, pop_do, full;
  logic [IdW-1:0] push_id;
  logic           twe;
  logic [TIW-1:0] twaddr;
  slot_t          twdata;

  assign need_walk = (cmd_q == CMD_TICK) ||
                     ((cmd_q == CMD_TIMED) && (delay_q != '0) && (id_q != '0));
  assign cur_valid = tvalid_q[idx_q];
  assign last_slot = (idx_q == TIW'(TIMER_SLOTS - 1));
  assign match     = cur_valid && (trd_q.task_id == id_q);
  assign full      = (fill_q == FW'(QUEUE_SLOTS));

  assign stat_o.need_walk = need_walk;
  assign stat_o.walk_done = last_slot || ((cmd_q == CMD_TIMED) && match);

  // queue push source: expired timer slot during a tick, the item on finish
  always_comb begin
    push_req = 1'b0;
    push_id  = id_q;
    if (ctl_i.step && (cmd_q == CMD_TICK)) begin
      push_req = cur_valid && (trd_q.count == '0);
      push_id  = trd_q.task_id;
    end else if (ctl_i.finish) begin
      push_req = (cmd_q == CMD_ADD) || ((cmd_q == CMD_TIMED) && (delay_q == '0));
    end
  end

  assign push_do   = push_req && (push_id != '0) && !full;
  assign push_lost = push_req && (push_id != '0) && full;
  assign pop_do    = ctl_i.finish && (cmd_q == CMD_DISPATCH) && (fill_q != '0);

  always_comb begin
    fill_d = fill_q;
    head_d = head_q;
    tail_d = tail_q;
    if (push_do) begin
      fill_d = fill_q + FW'(1);
      tail_d = (tail_q == QIW'(QUEUE_SLOTS - 1)) ? '0 : tail_q + QIW'(1);
    end else if (pop_do) begin
      fill_d = fill_q - FW'(1);
      head_d = (head_q == QIW'(QUEUE_SLOTS - 1)) ? '0 : head_q + QIW'(1);
    end
  end

  // timer table write port and occupancy
  always_comb begin
    twe      = 1'b0;
    twaddr   = idx_q;
    twdata   = trd_q;
    tvalid_d = tvalid_q;
    status_d = status_q;
    if (push_lost) begin
      status_d = ST_QFULL;
    end
    if (ctl_i.step) begin
      if (cmd_q == CMD_TICK) begin
        if (cur_valid) begin
          if (trd_q.count != '0) begin
            twe          = 1'b1;
            twdata.count = trd_q.count - DelayW'(1);
          end else begin
            tvalid_d[idx_q] = 1'b0;
          end
        end
      end else if (match) begin
        twe    = 1'b1;
        twdata = '{task_id: id_q, count: delay_q - DelayW'(1)};
      end
    end else if (ctl_i.finish && (cmd_q == CMD_TIMED) && need_walk && !hit_q) begin
      if (free_found_q) begin
        twe                  = 1'b1;
        twaddr               = free_idx_q;
        twdata               = '{task_id: id_q, count: delay_q - DelayW'(1)};
        tvalid_d[free_idx_q] = 1'b1;
      end else begin
        status_d = ST_TFULL;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q   <= req_i.cmd;
      id_q    <= req_i.task_id[IdW-1:0];
      delay_q <= req_i.delay;
    end
    if (push_do) begin
      qmem[tail_q] <= push_id;
    end
    qrd_q <= qmem[head_q];
    if (twe) begin
      tmem[twaddr] <= twdata;
    end
    trd_q <= tmem[idx_q];
    if (ctl_i.step && (cmd_q == CMD_TIMED) && !cur_valid && !free_found_q) begin
      free_idx_q <= idx_q;
    end
    if (ctl_i.finish) begin
      res_q.head_task   <= pop_do ? IdFieldW'(qrd_q) : '0;
      res_q.dispatched  <= pop_do;
      res_q.status      <= status_d;
      res_q.ready_count <= CountW'(fill_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      fill_q       <= '0;
      tvalid_q     <= '0;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      status_q     <= ST_OK;
      done_q       <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      fill_q   <= fill_d;
      tvalid_q <= tvalid_d;
      done_q   <= ctl_i.finish;
      if (ctl_i.load) begin
        idx_q        <= '0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
        status_q     <= ST_OK;
      end else begin
        status_q <= status_d;
        if (ctl_i.step) begin
          idx_q <= idx_q + TIW'(1);
          if ((cmd_q == CMD_TIMED) && match) begin
            hit_q <= 1'b1;
          end
          if ((cmd_q == CMD_TIMED) && !cur_valid) begin
            free_found_q <= 1'b1;
          end
        end
      end
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

### rtl/task_queue_timer_scheduler_top.sv
// Top level of the task queue and timer scheduler.
`default_nettype none

// Takes one command per item (add, timed add, tick, dispatch) while busy is
// low and shows exactly one result on res_o for a single cycle with done_o;
// the receiver cannot stall, so capture it then. Add, dispatch, a timed add
// with zero delay and any add of the idle task pass from setup straight to
// finish. A tick walks every timer slot and a timed add walks slots until it
// finds the same task or reaches the last slot, with a read state and a
// process state per slot visited, as the timer table read is registered. A
// new item may be started in the cycle its predecessor's result is shown.
module task_queue_timer_scheduler_top #(
  parameter int unsigned QUEUE_SLOTS  = 8,
  parameter int unsigned TIMER_SLOTS  = 8,
  parameter int unsigned TASK_ID_BITS = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  tqts_pkg::req_t      req_i,
  output tqts_pkg::res_t      res_o,
  output logic                done_o
);
  import tqts_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  tqts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  tqts_dp #(
    .QUEUE_SLOTS  (QUEUE_SLOTS),
    .TIMER_SLOTS  (TIMER_SLOTS),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ctl_i  (ctl),
    .stat_o (stat),
    .res_o  (res_o),
    .done_o (done_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  a_finish_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.finish |=> done_o)
    else $error("finished item produced no result");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_dispatch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.dispatched |-> res_o.status == ST_OK && res_o.head_task != '0)
    else $error("dispatched item carries bad status or idle task");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the task queue and timer scheduler.
`timescale 1ns / 100ps

module tb_top;
  import tqts_pkg::*;

  localparam int unsigned QueueSlots = 8;
  localparam int unsigned TimerSlots = 8;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned PhaseItems = 420;

  typedef struct {
    req_t        req;
    int unsigned gap_pct;
  } pend_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic drv_start = 1'b0;
  req_t drv_req = '0;
  logic busy;
  res_t res_o;
  logic done_o;

  pend_t pending_items[$];
  res_t  expected_results[$];
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned cur_gap_pct = 33;
  int unsigned phase_items = 0;

  // scheduler state as the block should hold it
  logic [7:0]  ready_ids[QueueSlots];
  int unsigned ready_fill = 0;
  logic [7:0]  timer_ids[TimerSlots];
  logic [7:0]  timer_cnt[TimerSlots];

  wire item_taken = drv_start && !busy;

  task_queue_timer_scheduler_top #(
    .QUEUE_SLOTS (QueueSlots),
    .TIMER_SLOTS (TimerSlots),
    .TASK_ID_BITS(8)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (drv_start),
    .busy  (busy),
    .req_i (drv_req),
    .res_o (res_o),
    .done_o(done_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit enqueue_ready(logic [7:0] id);
    if (id == 8'd0) return 1'b1;
    if (ready_fill >= QueueSlots) return 1'b0;
    ready_ids[ready_fill] = id;
    ready_fill++;
    return 1'b1;
  endfunction

  function automatic res_t schedule_step(req_t r);
    res_t    res;
    status_e st;
    bit      placed;
    res = '0;
    st = ST_OK;
    placed = 1'b0;
    case (r.cmd)
      CMD_ADD: begin
        if (!enqueue_ready(r.task_id)) st = ST_QFULL;
      end
      CMD_TIMED: begin
        if (r.delay == 8'd0) begin
          if (!enqueue_ready(r.task_id)) st = ST_QFULL;
        end else if (r.task_id != 8'd0) begin
          // reload a slot holding the same task, else take the first free one
          for (int i = 0; i < TimerSlots; i++) begin
            if (!placed && timer_ids[i] == r.task_id) begin
              timer_cnt[i] = r.delay - 8'd1;
              placed = 1'b1;
            end
          end
          for (int i = 0; i < TimerSlots; i++) begin
            if (!placed && timer_ids[i] == 8'd0) begin
              timer_ids[i] = r.task_id;
              timer_cnt[i] = r.delay - 8'd1;
              placed = 1'b1;
            end
          end
          if (!placed) st = ST_TFULL;
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < TimerSlots; i++) begin
          if (timer_ids[i] != 8'd0) begin
            if (timer_cnt[i] != 8'd0) begin
              timer_cnt[i]--;
            end else begin
              if (!enqueue_ready(timer_ids[i])) st = ST_QFULL;
              timer_ids[i] = 8'd0;
            end
          end
        end
      end
      CMD_DISPATCH: begin
        if (ready_fill != 0) begin
          res.head_task = ready_ids[0];
          res.dispatched = 1'b1;
          for (int i = 0; i < QueueSlots - 1; i++) ready_ids[i] = ready_ids[i + 1];
          ready_ids[QueueSlots - 1] = 8'd0;
          ready_fill--;
        end
      end
      default: ;
    endcase
    res.status = st;
    res.ready_count = ready_fill[3:0];
    return res;
  endfunction

  task automatic add_item(cmd_e c, logic [7:0] id, logic [7:0] d);
    pend_t p;
    p.req.cmd = c;
    p.req.task_id = id;
    p.req.delay = d;
    p.gap_pct = cur_gap_pct;
    pending_items.push_back(p);
    // adds of the idle task change nothing
    if (!((c == CMD_ADD || c == CMD_TIMED) && id == 8'd0)) phase_items++;
  endtask

  function automatic logic [7:0] pick_id();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 65) return 8'($urandom_range(1, 12));
    if (k < 72) return 8'd0;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_delay();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 20) return 8'd0;
    if (k < 70) return 8'($urandom_range(1, 4));
    return 8'($urandom_range(255));
  endfunction

  task automatic random_phase(int unsigned gap_pct);
    int unsigned kind;
    int unsigned n;
    logic [7:0]  id;
    cur_gap_pct = gap_pct;
    phase_items = 0;
    while (phase_items < PhaseItems) begin
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2, 3: add_item(cmd_e'($urandom_range(3)), pick_id(), pick_delay());
        4: begin
          n = $urandom_range(6, 10);
          repeat (n) add_item(CMD_ADD, 8'($urandom_range(1, 255)), 8'($urandom_range(255)));
        end
        5: begin
          n = $urandom_range(3, 10);
          repeat (n) add_item(CMD_DISPATCH, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        6: begin
          // load the timer table, at times past its size, then tick it
          n = $urandom_range(6, 10);
          for (int i = 0; i < n; i++)
            add_item(CMD_TIMED, 8'(i + $urandom_range(1, 3)), 8'($urandom_range(1, 8)));
          n = $urandom_range(1, 10);
          repeat (n) add_item(CMD_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        7: begin
          n = $urandom_range(1, 12);
          repeat (n) add_item(CMD_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        8: begin
          id = 8'($urandom_range(1, 255));
          add_item(CMD_TIMED, id, 8'($urandom_range(100, 255)));
          add_item(CMD_TIMED, id, 8'($urandom_range(1, 3)));
          n = $urandom_range(1, 4);
          repeat (n) add_item(CMD_TICK, 8'd0, 8'd0);
        end
        default: add_item(CMD_TIMED, pick_id(), 8'd0);
      endcase
    end
  endtask

  // driver: hold an item until taken, then present the next after a random gap
  always @(posedge clk_i or negedge rst_ni) begin
    pend_t nxt;
    if (!rst_ni) begin
      drv_start <= 1'b0;
      drv_req <= '0;
    end else begin
      if (item_taken) expected_results.push_back(schedule_step(drv_req));
      if (!drv_start || !busy) begin
        if (pending_items.size() != 0 &&
            $urandom_range(99) >= pending_items[0].gap_pct) begin
          nxt = pending_items.pop_front();
          drv_req <= nxt.req;
          drv_start <= 1'b1;
        end else begin
          drv_start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result against the oldest expectation
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: head_task %0d dispatched %0d status %0d ready_count %0d",
               res_o.head_task, res_o.dispatched, res_o.status, res_o.ready_count);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_o.head_task !== want.head_task) begin
          $error("head_task: expected %0d, got %0d", want.head_task, res_o.head_task);
          fail_count++;
        end
        if (res_o.dispatched !== want.dispatched) begin
          $error("dispatched: expected %0d, got %0d", want.dispatched, res_o.dispatched);
          fail_count++;
        end
        if (res_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_o.status);
          fail_count++;
        end
        if (res_o.ready_count !== want.ready_count) begin
          $error("ready_count: expected %0d, got %0d", want.ready_count, res_o.ready_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_taken || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < QueueSlots; i++) ready_ids[i] = 8'd0;
    for (int i = 0; i < TimerSlots; i++) begin
      timer_ids[i] = 8'd0;
      timer_cnt[i] = 8'd0;
    end

    // directed: empty dispatch, idle task, full queue, tick into full queue,
    // reload, expiry after a few ticks
    cur_gap_pct = 33;
    add_item(CMD_DISPATCH, 8'hFF, 8'hFF);
    add_item(CMD_ADD, 8'd0, 8'd0);
    add_item(CMD_TIMED, 8'd0, 8'd5);
    add_item(CMD_TIMED, 8'h80, 8'd0);
    add_item(CMD_ADD, 8'hFF, 8'hFF);
    for (int i = 1; i <= 6; i++) add_item(CMD_ADD, 8'(i), 8'd0);
    add_item(CMD_ADD, 8'h55, 8'd0);
    add_item(CMD_TIMED, 8'h55, 8'd0);
    add_item(CMD_TIMED, 8'hAA, 8'd1);
    add_item(CMD_TICK, 8'd0, 8'd0);
    add_item(CMD_DISPATCH, 8'd0, 8'd0);
    add_item(CMD_TIMED, 8'h33, 8'hFF);
    add_item(CMD_TIMED, 8'h33, 8'd2);
    repeat (3) add_item(CMD_TICK, 8'd0, 8'd0);
    add_item(CMD_DISPATCH, 8'd0, 8'd0);

    random_phase(33);
    random_phase(83);
    random_phase(0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || drv_start || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
